>>> rtl/core/dht_pkg.sv
// Shared constants, types and the residue step for the double-hash table.
// No dependencies; imported by every module of the block.
`default_nettype none
package dht_pkg;

  localparam int unsigned SLOTS    = 13;
  localparam int unsigned STEP_MOD = 7;

  localparam int unsigned KEY_W  = 31;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OUT_W  = 4;

  localparam int unsigned MAX_MOD = (SLOTS > STEP_MOD) ? SLOTS : STEP_MOD;
  localparam int unsigned MOD_W   = $clog2(MAX_MOD + 1);
  localparam int unsigned ACC_W   = MOD_W + 4;
  localparam int unsigned IDX_W   = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int unsigned POS_W   = $clog2(SLOTS + STEP_MOD + 1);
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

  // key is reduced one nibble a beat, most significant first
  localparam int unsigned NIBS    = (KEY_W + 3) / 4;
  localparam int unsigned NIB_CW  = (NIBS > 1) ? $clog2(NIBS) : 1;
  localparam int unsigned PAD_W   = NIBS * 4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  typedef enum logic [1:0] {
    WR_INSERT = 2'd0,
    WR_DELETE = 2'd1,
    WR_MODIFY = 2'd2
  } wr_op_e;

  typedef struct packed {
    logic             en;
    wr_op_e           op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } wr_req_t;

  // (16*r + nib) mod m for r < m: at most one restoring subtract per weight
  function automatic logic [MOD_W-1:0] red_nib(logic [MOD_W-1:0] r, logic [3:0] nib,
                                               logic [MOD_W-1:0] m);
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] mm;
    acc = {r, nib};
    for (int k = 3; k >= 0; k--) begin
      mm = ACC_W'(m) << k;
      if (acc >= mm) begin
        acc = acc - mm;
      end
    end
    return acc[MOD_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dht_residue.sv
// Iterative residue unit: key mod SLOTS and key mod STEP_MOD, one nibble a cycle.
// Depends on dht_pkg.
`default_nettype none
module dht_residue import dht_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KEY_W-1:0] key_i,
  output logic                  done_o,
  output logic [MOD_W-1:0]      home_o,
  output logic [MOD_W-1:0]      step_res_o
);

  logic [PAD_W-1:0]  sh_q, sh_d;
  logic [MOD_W-1:0]  rs_q, rs_d, rt_q, rt_d;
  logic [NIB_CW-1:0] cnt_q, cnt_d;
  logic              run_q, run_d, done_q, done_d;

  always_comb begin
    sh_d   = sh_q;
    rs_d   = rs_q;
    rt_d   = rt_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d  = PAD_W'(key_i);
      rs_d  = '0;
      rt_d  = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rs_d  = red_nib(rs_q, sh_q[PAD_W-1 -: 4], MOD_W'(SLOTS));
      rt_d  = red_nib(rt_q, sh_q[PAD_W-1 -: 4], MOD_W'(STEP_MOD));
      sh_d  = sh_q << 4;
      cnt_d = cnt_q + NIB_CW'(1);
      if (cnt_q == NIB_CW'(NIBS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    rs_q <= rs_d;
    rt_q <= rt_d;
  end

  assign done_o     = done_q;
  assign home_o     = rs_q;
  assign step_res_o = rt_q;

endmodule
`default_nettype wire

>>> rtl/core/dht_slot_store.sv
// Slot store: used flags, stored keys and occupancy count, one write a cycle.
// Depends on dht_pkg.
`default_nettype none
module dht_slot_store import dht_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output logic                  rd_used_o,
  output logic [KEY_W-1:0]      rd_key_o,
  input  wire wr_req_t          wr_i,
  output logic [CNT_W-1:0]      count_o
);

  logic [SLOTS-1:0] used_q;
  logic [KEY_W-1:0] key_q [SLOTS];
  logic [CNT_W-1:0] count_q;

  assign rd_used_o = used_q[rd_idx_i];
  assign rd_key_o  = key_q[rd_idx_i];
  assign count_o   = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
    end else if (wr_i.en) begin
      case (wr_i.op)
        WR_INSERT: begin
          used_q[wr_i.idx] <= 1'b1;
          count_q          <= count_q + CNT_W'(1);
        end
        WR_DELETE: begin
          used_q[wr_i.idx] <= 1'b0;
          if (count_q != '0) begin
            count_q <= count_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.op == WR_INSERT || wr_i.op == WR_MODIFY)) begin
      key_q[wr_i.idx] <= wr_i.key;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/double_hash_table_top.sv
// Top level of the double-hash table: command sequencer and result register.
// Depends on dht_pkg, dht_residue and dht_slot_store.
//
// A command beat is taken when start_i is high and busy_o low; busy_o then stays high
// until the result has been shown. The residue unit reduces the key four bits a cycle,
// then the sequencer reads one slot per cycle until a hit or until the position falls
// out of range, which ends a miss or a full insert. The result is on the result ports
// for exactly one cycle, marked by valid_o; the receiver cannot stall it, so it must
// capture the beat in that cycle.
`default_nettype none
module double_hash_table_top import dht_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [KEY_W-1:0]  new_value_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output logic [STAT_W-1:0]      status_o,
  output logic [KEY_W-1:0]       found_value_o,
  output logic [OUT_W-1:0]       slot_o,
  output logic [OUT_W-1:0]       occupancy_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q, nval_q;
  logic [POS_W-1:0]  pos_q, pos_d, step_q, step_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [KEY_W-1:0]  found_q, found_d;
  logic [IDX_W-1:0]  slot_q, slot_d;

  logic              accept;
  logic              res_done;
  logic [MOD_W-1:0]  res_home, res_step;
  logic              rd_used;
  logic [KEY_W-1:0]  rd_key;
  logic [CNT_W-1:0]  count;
  wr_req_t           wr;
  logic              in_range, hit;

  logic [IDX_W+OUT_W-1:0] slot_ext;
  logic [CNT_W+OUT_W-1:0] cnt_ext;

  assign accept = start_i && (state_q == S_IDLE);

  dht_residue u_residue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .key_i      (key_i),
    .done_o     (res_done),
    .home_o     (res_home),
    .step_res_o (res_step)
  );

  dht_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (pos_q[IDX_W-1:0]),
    .rd_used_o (rd_used),
    .rd_key_o  (rd_key),
    .wr_i      (wr),
    .count_o   (count)
  );

  assign in_range = pos_q < POS_W'(SLOTS);
  assign hit      = (cmd_q == CMD_INSERT) ? !rd_used : (rd_used && (rd_key == key_q));

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    step_d  = step_q;
    stat_d  = stat_q;
    found_d = found_q;
    slot_d  = slot_q;
    wr.en   = 1'b0;
    wr.op   = WR_INSERT;
    wr.idx  = pos_q[IDX_W-1:0];
    wr.key  = (cmd_q == CMD_MODIFY) ? nval_q : key_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (res_done) begin
          pos_d   = POS_W'(res_home);
          step_d  = POS_W'(res_step) + POS_W'(1);
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        found_d = '0;
        slot_d  = '0;
        if (!in_range) begin
          stat_d  = (cmd_q == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_d = S_RESP;
        end else if (hit) begin
          stat_d  = ST_OK;
          slot_d  = pos_q[IDX_W-1:0];
          state_d = S_RESP;
          case (cmd_q)
            CMD_INSERT: begin
              wr.en = 1'b1;
              wr.op = WR_INSERT;
            end
            CMD_SEARCH: found_d = rd_key;
            CMD_DELETE: begin
              wr.en = 1'b1;
              wr.op = WR_DELETE;
            end
            CMD_MODIFY: begin
              wr.en = 1'b1;
              wr.op = WR_MODIFY;
            end
            default: ;
          endcase
        end else begin
          pos_d = pos_q + step_q;
        end
      end
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i;
      nval_q <= new_value_i;
    end
    pos_q   <= pos_d;
    step_q  <= step_d;
    stat_q  <= stat_d;
    found_q <= found_d;
    slot_q  <= slot_d;
  end

  assign slot_ext = {{OUT_W{1'b0}}, slot_q};
  assign cnt_ext  = {{OUT_W{1'b0}}, count};

  assign busy_o        = (state_q != S_IDLE);
  assign valid_o       = (state_q == S_RESP);
  assign status_o      = stat_q;
  assign found_value_o = found_q;
  assign slot_o        = slot_ext[OUT_W-1:0];
  assign occupancy_o   = cnt_ext[OUT_W-1:0];

endmodule
`default_nettype wire
